// ----- rtl/ucr_pkg.sv -----
// ucr_pkg: shared types, constants and helpers of the USB control request responder.
// Used by every module of the block; depends on nothing.
package ucr_pkg;

  // Descriptor memory size; must be a power of two.
  localparam int MEMORY_BYTES = 256;
  localparam int PACKET_BYTES = 64;
  localparam int MEM_AW       = $clog2(MEMORY_BYTES);
  localparam int OFS_W        = (MEM_AW > 8) ? MEM_AW : 8;
  localparam int PKT_W        = $clog2(PACKET_BYTES + 1);
  localparam int QDEPTH       = 2;
  localparam int QPW          = $clog2(QDEPTH);
  localparam int QCW          = $clog2(QDEPTH + 1);
  localparam int LC_BYTES     = 7;

  localparam logic [7:0] KIND_MASK  = 8'h60;
  localparam logic [7:0] KIND_STD   = 8'h00;
  localparam logic [7:0] KIND_CLASS = 8'h20;

  localparam logic [7:0] RC_GET_STATUS     = 8'h00;
  localparam logic [7:0] RC_SET_ADDRESS    = 8'h05;
  localparam logic [7:0] RC_GET_DESCRIPTOR = 8'h06;
  localparam logic [7:0] RC_GET_CONFIG     = 8'h08;
  localparam logic [7:0] RC_SET_CONFIG     = 8'h09;
  localparam logic [7:0] RC_SET_LINE_CODE  = 8'h20;
  localparam logic [7:0] RC_GET_LINE_CODE  = 8'h21;
  localparam logic [7:0] RC_SET_CTRL_LINE  = 8'h22;
  localparam logic [7:0] RC_SEND_BREAK     = 8'h23;

  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_SETUP   = 3'd1,
    OP_IN_EMPTY = 3'd2,
    OP_OUT_DATA = 3'd3,
    OP_BUS_RST = 3'd4,
    OP_VBUS_LOST = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ACT_DATA  = 3'd0,
    ACT_ZLP   = 3'd1,
    ACT_STALL = 3'd2,
    ACT_ACK   = 3'd3,
    ACT_ARM   = 3'd4,
    ACT_MORE  = 3'd5,
    ACT_PIPES = 3'd6,
    ACT_NONE  = 3'd7
  } act_e;

  typedef enum logic [1:0] {
    SRC_MEM    = 2'd0,
    SRC_CFGVAL = 2'd1,
    SRC_STATUS = 2'd2,
    SRC_LINE   = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    REG_DEV_BASE  = 2'd0,
    REG_CFG_BASE  = 2'd1,
    REG_STR_DIR   = 2'd2,
    REG_STR_COUNT = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CMD_LOAD, CMD_SETUP, CMD_IN_EMPTY, CMD_OUT_DATA, CMD_BUS_RST, CMD_NONE
  } cmd_e;

  typedef enum logic [3:0] {
    RQ_DEV, RQ_CFG, RQ_STR, RQ_ADDR, RQ_SETCFG, RQ_GETCFG, RQ_STATUS,
    RQ_SETLC, RQ_ACK, RQ_GETLC, RQ_STALL
  } req_e;

  typedef enum logic [3:0] {
    B_IDLE, B_EXEC, B_DLEN, B_CLO, B_CHI, B_SDIR, B_SLEN, B_ACK,
    B_PKT, B_BYTE, B_BWAIT
  } bstate_e;

  typedef struct packed {
    cmd_e        op;
    req_e        req;
    logic [7:0]  addr;
    logic [7:0]  data;
    logic [7:0]  value_lo;
    logic        value_nz;
    logic [15:0] length;
    logic [6:0]  out_count;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [7:0] dev_base;
    logic [7:0] cfg_base;
    logic [7:0] str_dir;
    logic [4:0] str_count;
  } cfg_t;

  function automatic logic [7:0] line_coding(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd1:    b = 8'hC2;
      3'd2:    b = 8'h01;
      3'd6:    b = 8'h08;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [OFS_W:0] widen8(input logic [7:0] b);
    return (OFS_W + 1)'(b);
  endfunction

  function automatic logic [MEM_AW-1:0] mem_addr(input logic [OFS_W:0] a);
    return a[MEM_AW-1:0];
  endfunction

endpackage

// ----- rtl/ucr_if.sv -----
// ucr_if: request and response channel interfaces of the control responder.
// Depends on nothing.
interface ucr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  load_addr;
  logic [7:0]  load_data;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_length;
  logic [6:0]  out_count;
  modport source(output valid, op, load_addr, load_data, request_type, request_code,
                 request_value, request_length, out_count, input ready);
  modport sink(input valid, op, load_addr, load_data, request_type, request_code,
               request_value, request_length, out_count, output ready);
endinterface

interface ucr_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] data_byte;
  logic       short_commit;
  logic       last;
  logic       configured;
  logic       bulk_allowed;
  modport source(output valid, action, data_byte, short_commit, last, configured,
                 bulk_allowed, input ready);
  modport sink(input valid, action, data_byte, short_commit, last, configured,
               bulk_allowed, output ready);
endinterface

// ----- rtl/ucr_front.sv -----
// ucr_front: accepts request items and classifies them into commands.
// Depends on ucr_pkg and ucr_if.
module ucr_front import ucr_pkg::*; (
  ucr_req_if.sink req_i,
  input  q_stat_t qstat_i,
  output logic    push_o,
  output cmd_t    cmd_o
);

  logic [7:0] kind;

  assign req_i.ready = !qstat_i.full;
  assign push_o      = req_i.valid && !qstat_i.full;
  assign kind        = req_i.request_type & KIND_MASK;

  always_comb begin
    cmd_o.addr      = req_i.load_addr;
    cmd_o.data      = req_i.load_data;
    cmd_o.value_lo  = req_i.request_value[7:0];
    cmd_o.value_nz  = (req_i.request_value != 16'd0);
    cmd_o.length    = req_i.request_length;
    cmd_o.out_count = req_i.out_count;
    case (op_e'(req_i.op))
      OP_LOAD:      cmd_o.op = CMD_LOAD;
      OP_SETUP:     cmd_o.op = CMD_SETUP;
      OP_IN_EMPTY:  cmd_o.op = CMD_IN_EMPTY;
      OP_OUT_DATA:  cmd_o.op = CMD_OUT_DATA;
      OP_BUS_RST:   cmd_o.op = CMD_BUS_RST;
      OP_VBUS_LOST: cmd_o.op = CMD_BUS_RST;
      default:      cmd_o.op = CMD_NONE;
    endcase
    cmd_o.req = RQ_STALL;
    if (kind == KIND_STD) begin
      case (req_i.request_code)
        RC_GET_DESCRIPTOR: begin
          if (req_i.request_value[15:8] == DT_DEVICE) cmd_o.req = RQ_DEV;
          else if (req_i.request_value[15:8] == DT_CONFIG) cmd_o.req = RQ_CFG;
          else if (req_i.request_value[15:8] == DT_STRING) cmd_o.req = RQ_STR;
        end
        RC_SET_ADDRESS: cmd_o.req = RQ_ADDR;
        RC_SET_CONFIG:  cmd_o.req = RQ_SETCFG;
        RC_GET_CONFIG:  cmd_o.req = RQ_GETCFG;
        RC_GET_STATUS:  cmd_o.req = RQ_STATUS;
        default:        cmd_o.req = RQ_STALL;
      endcase
    end else if (kind == KIND_CLASS) begin
      case (req_i.request_code)
        RC_SET_LINE_CODE: cmd_o.req = RQ_SETLC;
        RC_SET_CTRL_LINE: cmd_o.req = RQ_ACK;
        RC_SEND_BREAK:    cmd_o.req = RQ_ACK;
        RC_GET_LINE_CODE: cmd_o.req = RQ_GETLC;
        default:          cmd_o.req = RQ_STALL;
      endcase
    end
  end

endmodule

// ----- rtl/ucr_queue.sv -----
// ucr_queue: short command queue between the front and the back.
// Depends on ucr_pkg.
module ucr_queue import ucr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    head_o,
  output q_stat_t stat_o
);

  cmd_t           ent_q [QDEPTH];
  logic [QPW-1:0] wr_q, rd_q;
  logic [QCW-1:0] cnt_q;

  assign head_o       = ent_q[rd_q];
  assign stat_o.full  = (cnt_q == QCW'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == QPW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == QPW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- rtl/ucr_back.sv -----
// ucr_back: executes commands: descriptor memory, transfer state and reply streaming.
// Depends on ucr_pkg and ucr_if.
module ucr_back import ucr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  cmd_t    head_i,
  input  q_stat_t qstat_i,
  output logic    pop_o,
  ucr_rsp_if.source rsp_o
);

  bstate_e          state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic             conf_q, conf_d;
  src_e             src_q, src_d;
  logic [OFS_W-1:0] ofs_q, ofs_d;
  logic [15:0]      rl_q, rl_d, rx_q, rx_d;
  logic [7:0]       lo_q, lo_d, sb_q, sb_d;
  logic [PKT_W-1:0] pn_q, pn_d, cnt_q, cnt_d;
  logic             ov_q, ov_d;
  act_e             oact_q, oact_d;
  logic [7:0]       odat_q, odat_d;
  logic             osc_q, osc_d, olast_q, olast_d, oconf_q, oconf_d, obulk_q, obulk_d;

  logic [7:0]        mem [MEMORY_BYTES];
  logic [7:0]        rdata_q;
  logic [MEM_AW-1:0] raddr;
  logic              we;

  logic             can_emit, emit, e_sc, e_last;
  act_e             e_act;
  logic [7:0]       e_data;
  logic [15:0]      len, req_len;
  logic [PKT_W-1:0] n;

  assign can_emit = !ov_q || rsp_o.ready;

  assign rsp_o.valid        = ov_q;
  assign rsp_o.action       = oact_q;
  assign rsp_o.data_byte    = odat_q;
  assign rsp_o.short_commit = osc_q;
  assign rsp_o.last         = olast_q;
  assign rsp_o.configured   = oconf_q;
  assign rsp_o.bulk_allowed = obulk_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[mem_addr(widen8(cmd_q.addr))] <= cmd_q.data;
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    conf_d  = conf_q;
    src_d   = src_q;
    ofs_d   = ofs_q;
    rl_d    = rl_q;
    rx_d    = rx_q;
    lo_d    = lo_q;
    sb_d    = sb_q;
    pn_d    = pn_q;
    cnt_d   = cnt_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    raddr   = ofs_q[MEM_AW-1:0];
    emit    = 1'b0;
    e_act   = ACT_NONE;
    e_data  = 8'd0;
    e_sc    = 1'b0;
    e_last  = 1'b1;
    len     = 16'd0;
    req_len = cmd_q.length;
    n       = (rl_q < 16'(PACKET_BYTES)) ? PKT_W'(rl_q) : PKT_W'(PACKET_BYTES);

    case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o   = 1'b1;
          cmd_d   = head_i;
          state_d = B_EXEC;
        end
      end
      B_EXEC: begin
        case (cmd_q.op)
          CMD_LOAD: begin
            we      = 1'b1;
            state_d = B_IDLE;
          end
          CMD_SETUP: begin
            rl_d = 16'd0;
            rx_d = 16'd0;
            case (cmd_q.req)
              RQ_DEV: begin
                raddr   = mem_addr(widen8(cfg_i.dev_base));
                state_d = B_DLEN;
              end
              RQ_CFG: begin
                raddr   = mem_addr(widen8(cfg_i.cfg_base) + (OFS_W + 1)'(2));
                state_d = B_CLO;
              end
              RQ_STR: begin
                if (cmd_q.value_lo < {3'b000, cfg_i.str_count}) begin
                  raddr   = mem_addr(widen8(cfg_i.str_dir) + widen8(cmd_q.value_lo));
                  state_d = B_SDIR;
                end else begin
                  emit  = can_emit;
                  e_act = ACT_STALL;
                  if (can_emit) state_d = B_IDLE;
                end
              end
              RQ_SETCFG: begin
                if (can_emit) begin
                  conf_d = cmd_q.value_nz;
                  emit   = 1'b1;
                  if (cmd_q.value_nz) begin
                    e_act   = ACT_PIPES;
                    e_last  = 1'b0;
                    state_d = B_ACK;
                  end else begin
                    e_act   = ACT_ACK;
                    state_d = B_IDLE;
                  end
                end
              end
              RQ_GETCFG, RQ_STATUS, RQ_GETLC: begin
                if (cmd_q.req == RQ_GETCFG) begin
                  src_d = SRC_CFGVAL;
                  len   = 16'd1;
                end else if (cmd_q.req == RQ_STATUS) begin
                  src_d = SRC_STATUS;
                  len   = 16'd2;
                end else begin
                  src_d = SRC_LINE;
                  len   = 16'(LC_BYTES);
                end
                ofs_d   = '0;
                rl_d    = (len < req_len) ? len : req_len;
                state_d = B_PKT;
              end
              RQ_SETLC: begin
                emit = can_emit;
                if (cmd_q.length != 16'd0) begin
                  rx_d  = cmd_q.length;
                  e_act = ACT_ARM;
                end else begin
                  e_act = ACT_ACK;
                end
                if (can_emit) state_d = B_IDLE;
              end
              RQ_ADDR, RQ_ACK: begin
                emit  = can_emit;
                e_act = ACT_ACK;
                if (can_emit) state_d = B_IDLE;
              end
              default: begin
                emit  = can_emit;
                e_act = ACT_STALL;
                if (can_emit) state_d = B_IDLE;
              end
            endcase
          end
          CMD_IN_EMPTY: begin
            if (rl_q != 16'd0) begin
              state_d = B_PKT;
            end else begin
              emit  = can_emit;
              e_act = ACT_ACK;
              if (can_emit) state_d = B_IDLE;
            end
          end
          CMD_OUT_DATA: begin
            // Count the data down only once, at the cycle that sends the answer.
            if (can_emit) begin
              emit    = 1'b1;
              state_d = B_IDLE;
              if (rx_q == 16'd0) begin
                e_act = ACT_NONE;
              end else begin
                rx_d  = (16'(cmd_q.out_count) >= rx_q) ? 16'd0 : rx_q - 16'(cmd_q.out_count);
                e_act = (rx_d == 16'd0) ? ACT_ACK : ACT_MORE;
              end
            end
          end
          CMD_BUS_RST: begin
            conf_d = 1'b0;
            rl_d   = 16'd0;
            rx_d   = 16'd0;
            emit   = can_emit;
            e_act  = ACT_NONE;
            if (can_emit) state_d = B_IDLE;
          end
          default: begin
            emit  = can_emit;
            e_act = ACT_NONE;
            if (can_emit) state_d = B_IDLE;
          end
        endcase
      end
      B_DLEN: begin
        len     = {8'd0, rdata_q};
        src_d   = SRC_MEM;
        ofs_d   = OFS_W'(mem_addr(widen8(cfg_i.dev_base)));
        rl_d    = (len < req_len) ? len : req_len;
        state_d = B_PKT;
      end
      B_CLO: begin
        lo_d    = rdata_q;
        raddr   = mem_addr(widen8(cfg_i.cfg_base) + (OFS_W + 1)'(3));
        state_d = B_CHI;
      end
      B_CHI: begin
        len     = {rdata_q, lo_q};
        src_d   = SRC_MEM;
        ofs_d   = OFS_W'(mem_addr(widen8(cfg_i.cfg_base)));
        rl_d    = (len < req_len) ? len : req_len;
        state_d = B_PKT;
      end
      B_SDIR: begin
        sb_d    = rdata_q;
        raddr   = mem_addr(widen8(rdata_q));
        state_d = B_SLEN;
      end
      B_SLEN: begin
        if (rdata_q == 8'd0) begin
          emit  = can_emit;
          e_act = ACT_STALL;
          if (can_emit) state_d = B_IDLE;
        end else begin
          len     = {8'd0, rdata_q};
          src_d   = SRC_MEM;
          ofs_d   = OFS_W'(mem_addr(widen8(sb_q)));
          rl_d    = (len < req_len) ? len : req_len;
          state_d = B_PKT;
        end
      end
      B_ACK: begin
        emit  = can_emit;
        e_act = ACT_ACK;
        if (can_emit) state_d = B_IDLE;
      end
      B_PKT: begin
        if (n == '0) begin
          emit  = can_emit;
          e_act = ACT_ZLP;
          e_sc  = 1'b1;
          if (can_emit) state_d = B_IDLE;
        end else begin
          pn_d    = n;
          cnt_d   = n;
          rl_d    = rl_q - 16'(n);
          state_d = B_BYTE;
        end
      end
      B_BYTE, B_BWAIT: begin
        if (src_q == SRC_MEM && state_q == B_BYTE) begin
          state_d = B_BWAIT;
        end else if (can_emit) begin
          emit   = 1'b1;
          e_act  = ACT_DATA;
          e_last = (cnt_q == PKT_W'(1));
          e_sc   = e_last && (pn_q < PKT_W'(PACKET_BYTES));
          cnt_d  = cnt_q - 1'b1;
          case (src_q)
            SRC_MEM:    e_data = rdata_q;
            SRC_CFGVAL: e_data = {7'd0, conf_q};
            SRC_STATUS: e_data = 8'd0;
            default:    e_data = line_coding((ofs_q < OFS_W'(LC_BYTES)) ? ofs_q[2:0] : 3'd0);
          endcase
          if (src_q == SRC_MEM) begin
            ofs_d = OFS_W'(mem_addr((OFS_W + 1)'(ofs_q) + (OFS_W + 1)'(1)));
            raddr = ofs_d[MEM_AW-1:0];
          end else begin
            ofs_d = OFS_W'(ofs_q[7:0] + 8'd1);
          end
          if (e_last) state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase

    ov_d    = emit ? 1'b1 : (rsp_o.ready ? 1'b0 : ov_q);
    oact_d  = emit ? e_act : oact_q;
    odat_d  = emit ? e_data : odat_q;
    osc_d   = emit ? e_sc : osc_q;
    olast_d = emit ? e_last : olast_q;
    oconf_d = emit ? conf_d : oconf_q;
    obulk_d = emit ? (conf_d && rl_d == 16'd0 && rx_d == 16'd0) : obulk_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      conf_q  <= 1'b0;
      src_q   <= SRC_MEM;
      ofs_q   <= '0;
      rl_q    <= 16'd0;
      rx_q    <= 16'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      conf_q  <= conf_d;
      src_q   <= src_d;
      ofs_q   <= ofs_d;
      rl_q    <= rl_d;
      rx_q    <= rx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    lo_q    <= lo_d;
    sb_q    <= sb_d;
    pn_q    <= pn_d;
    cnt_q   <= cnt_d;
    oact_q  <= oact_d;
    odat_q  <= odat_d;
    osc_q   <= osc_d;
    olast_q <= olast_d;
    oconf_q <= oconf_d;
    obulk_q <= obulk_d;
  end

endmodule

// ----- rtl/usb_control_request_responder_unit.sv -----
// Control endpoint responder: a CDC-ACM device's answers to USB control requests.
// A request is registered in the command queue, then popped into the back end; simple
// answers go to the output register, descriptor replies follow their header reads.
// Reply bytes stream one per cycle while the response sink is ready (a packet of up to
// 64 bytes), set by the single read port of the descriptor memory.
// Reset clears transfer state and the configured flag; memory contents stay undefined.
module usb_control_request_responder_unit import ucr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ucr_req_if.sink    req_i,
  ucr_rsp_if.source  rsp_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  cfg_t    cfg_q;
  cmd_t    push_cmd, head;
  logic    push, pop;
  q_stat_t qstat;

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_base  <= 8'd0;
      cfg_q.cfg_base  <= 8'd18;
      cfg_q.str_dir   <= 8'd85;
      cfg_q.str_count <= 5'd4;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DEV_BASE:  cfg_q.dev_base  <= cfg_wdata_i;
        REG_CFG_BASE:  cfg_q.cfg_base  <= cfg_wdata_i;
        REG_STR_DIR:   cfg_q.str_dir   <= cfg_wdata_i;
        REG_STR_COUNT: cfg_q.str_count <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // Front: accept and classify each request item.
  ucr_front u_front (
    .req_i   (req_i),
    .qstat_i (qstat),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // Queue: decouple classification from execution.
  ucr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  // Back: run each command against memory and transfer state, drive the response.
  ucr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty) else $error("pop from empty command queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full) else $error("push into full command queue");

  a_pop_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !pop) else $error("back end popped twice in a row");

endmodule
